// ===== hdl/rcpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcpc_pkg;

    localparam int CH_W      = 4;
    localparam int TS_W      = 32;
    localparam int WIDTH_W   = 16;
    localparam int DIR_W     = 2;
    localparam int MAG_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // iterative divider: |offset| * 255 over |span|
    localparam int DVD_W     = 24;
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BELOW = 2'd1;
    localparam logic [DIR_W-1:0] DIR_ABOVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_REVERSE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_FORWARD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_THRESHOLD = 3'd4;

    localparam logic [CFG_W-1:0] RST_DEADBAND_LOW     = 16'd1480;
    localparam logic [CFG_W-1:0] RST_DEADBAND_HIGH    = 16'd1520;
    localparam logic [CFG_W-1:0] RST_FULL_REVERSE     = 16'd1100;
    localparam logic [CFG_W-1:0] RST_FULL_FORWARD     = 16'd1900;
    localparam logic [CFG_W-1:0] RST_SIGNAL_THRESHOLD = 16'd700;

    localparam logic [MAG_W-1:0] MAG_FULL = 8'd255;

    typedef struct packed {
        logic capture;
        logic setup;
        logic div_start;
        logic load_out;
    } rcpc_cmd_t;

    typedef struct packed {
        logic item_ok;
        logic falling;
        logic div_done;
        logic out_free;
    } rcpc_status_t;

endpackage

`default_nettype wire

// ===== hdl/rcpc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rcpc_in_if
    import rcpc_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    logic            pin_level;
    logic [TS_W-1:0] timestamp_us;

    modport source (output valid, channel, pin_level, timestamp_us, input ready);
    modport sink (input valid, channel, pin_level, timestamp_us, output ready);
endinterface

`default_nettype wire

// ===== hdl/rcpc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rcpc_out_if
    import rcpc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_channel;
    logic [WIDTH_W-1:0] width_us;
    logic [DIR_W-1:0]   direction;
    logic [MAG_W-1:0]   magnitude;
    logic               signal_present;

    modport source (output valid, out_channel, width_us, direction, magnitude,
                    signal_present, input ready);
    modport sink (input valid, out_channel, width_us, direction, magnitude,
                  signal_present, output ready);
endinterface

`default_nettype wire

// ===== hdl/rcpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcpc_div
    import rcpc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic                  done
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       rem_shift;
    logic [DVS_W:0]       rem_sub;

    // restoring divide, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[DVS_W])
            begin
                rem_next = rem_sub[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== hdl/rcpc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcpc_datapath
    import rcpc_pkg::*;
#(
    parameter int NUM_CHANNELS = 11
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rcpc_cmd_t            cmd,
    output rcpc_status_t              status,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [CH_W-1:0]      in_channel,
    input  wire logic                 in_level,
    input  wire logic [TS_W-1:0]      in_ts,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [CH_W-1:0]           out_channel,
    output logic [WIDTH_W-1:0]        out_width,
    output logic [DIR_W-1:0]          out_direction,
    output logic [MAG_W-1:0]          out_magnitude,
    output logic                      out_present
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHX_W = 6;
    localparam int SQ_W  = DVD_W + 2;

    // configuration
    logic [CFG_W-1:0] db_low_reg, db_high_reg, full_rev_reg, full_fwd_reg, thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_low_reg   <= RST_DEADBAND_LOW;
            db_high_reg  <= RST_DEADBAND_HIGH;
            full_rev_reg <= RST_FULL_REVERSE;
            full_fwd_reg <= RST_FULL_FORWARD;
            thresh_reg   <= RST_SIGNAL_THRESHOLD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEADBAND_LOW:     db_low_reg   <= cfg_data;
                CFG_DEADBAND_HIGH:    db_high_reg  <= cfg_data;
                CFG_FULL_REVERSE:     full_rev_reg <= cfg_data;
                CFG_FULL_FORWARD:     full_fwd_reg <= cfg_data;
                CFG_SIGNAL_THRESHOLD: thresh_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // channel decode and start times
    logic [CHX_W-1:0] ch_ext;
    logic [IDX_W-1:0] idx;
    logic             ch_ok;
    logic [TS_W-1:0]  start_reg [NUM_CHANNELS];
    logic [TS_W-1:0]  start_rd;
    logic [TS_W-1:0]  diff;
    logic [WIDTH_W-1:0] w_sat;

    assign ch_ext   = {{(CHX_W-CH_W){1'b0}}, in_channel};
    assign idx      = ch_ext[IDX_W-1:0];
    assign ch_ok    = ch_ext < CHX_W'(NUM_CHANNELS);
    assign start_rd = ch_ok ? start_reg[idx] : '0;
    assign diff     = in_ts - start_rd;
    assign w_sat    = (|diff[TS_W-1:WIDTH_W]) ? {WIDTH_W{1'b1}} : diff[WIDTH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                start_reg[i] <= '0;
            end
        end
        else if (cmd.capture && ch_ok && in_level)
        begin
            start_reg[idx] <= in_ts;
        end
    end

    logic [WIDTH_W-1:0] w_reg;
    logic [CH_W-1:0]    ch_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            w_reg  <= w_sat;
            ch_reg <= in_channel;
        end
    end

    // classification and divider operands
    logic               in_band, below;
    logic [DIR_W-1:0]   dir_next;
    logic [WIDTH_W:0]   offset, span, off_abs17, span_abs17;
    logic [DVD_W-1:0]   num_next;
    logic [DIR_W-1:0]   dir_reg;
    logic [DVD_W-1:0]   num_reg;
    logic [DVS_W-1:0]   den_reg;
    logic               neg_reg, base_reg, zero_reg, full_reg;

    always_comb
    begin
        in_band = (w_reg >= db_low_reg) && (w_reg <= db_high_reg);
        below   = w_reg < db_low_reg;
        if (in_band)
            dir_next = DIR_STOP;
        else if (below)
            dir_next = DIR_BELOW;
        else
            dir_next = DIR_ABOVE;
        if (below)
        begin
            offset = {1'b0, w_reg} - {1'b0, full_rev_reg};
            span   = {1'b0, db_low_reg} - {1'b0, full_rev_reg};
        end
        else
        begin
            offset = {1'b0, w_reg} - {1'b0, db_high_reg};
            span   = {1'b0, full_fwd_reg} - {1'b0, db_high_reg};
        end
        off_abs17  = offset[WIDTH_W] ? (~offset + 1'b1) : offset;
        span_abs17 = span[WIDTH_W] ? (~span + 1'b1) : span;
        // times 255
        num_next = {off_abs17[WIDTH_W-1:0], 8'd0} - {8'd0, off_abs17[WIDTH_W-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            dir_reg  <= dir_next;
            num_reg  <= num_next;
            den_reg  <= span_abs17[DVS_W-1:0];
            // below the band the gain is negative
            neg_reg  <= offset[WIDTH_W] ^ span[WIDTH_W] ^ below;
            base_reg <= below;
            zero_reg <= in_band || (w_reg == '0);
            full_reg <= (span == '0);
        end
    end

    logic [DVD_W-1:0] quot;
    logic             div_done;

    rcpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .quotient (quot),
        .done     (div_done)
    );

    // signed quotient plus base, clamped to a byte
    logic [SQ_W-1:0]  sq, val;
    logic [MAG_W-1:0] mag;

    always_comb
    begin
        sq  = neg_reg ? (~{2'b00, quot} + 1'b1) : {2'b00, quot};
        val = sq + (base_reg ? SQ_W'(MAG_FULL) : '0);
        if (zero_reg)
            mag = '0;
        else if (full_reg)
            mag = MAG_FULL;
        else if (val[SQ_W-1])
            mag = '0;
        else if (|val[SQ_W-2:MAG_W])
            mag = MAG_FULL;
        else
            mag = val[MAG_W-1:0];
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_channel   <= ch_reg;
            out_width     <= w_reg;
            out_direction <= dir_reg;
            out_magnitude <= mag;
            out_present   <= w_reg > thresh_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.item_ok  = ch_ok;
    assign status.falling  = !in_level;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// ===== hdl/rcpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcpc_ctrl
    import rcpc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire rcpc_status_t status,
    output rcpc_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_WAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.setup     = 1'b0;
        cmd.div_start = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = accept;
                // rising edges and unknown channels finish here
                if (accept && status.item_ok && status.falling)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.load_out = status.out_free;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/rc_pulse_capture_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Multi-channel RC pulse capture. Each request on pulse_in is one pin edge:
// a rising edge stores the channel's start time, a falling edge measures the
// high time (saturated to 65535 us) and yields one result on result_out with
// width, direction relative to the deadband, a 0..255 magnitude and a
// signal-present flag. Rising edges and requests for channels at or above
// NUM_CHANNELS give no result. A falling edge runs through the shared
// divider, which retires one quotient bit per cycle over 24 bits; a
// finished result waits in the output register while the next request is
// taken. Write configuration only while no falling edge is in flight.
module rc_pulse_capture_decode
    import rcpc_pkg::*;
#(
    parameter int NUM_CHANNELS = 11
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rcpc_in_if.sink                   pulse_in,
    rcpc_out_if.source                result_out,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    rcpc_cmd_t    cmd;
    rcpc_status_t status;

    rcpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pulse_in.valid),
        .in_ready (pulse_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rcpc_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_channel    (pulse_in.channel),
        .in_level      (pulse_in.pin_level),
        .in_ts         (pulse_in.timestamp_us),
        .out_ready     (result_out.ready),
        .out_valid     (result_out.valid),
        .out_channel   (result_out.out_channel),
        .out_width     (result_out.width_us),
        .out_direction (result_out.direction),
        .out_magnitude (result_out.magnitude),
        .out_present   (result_out.signal_present)
    );

endmodule

`default_nettype wire

// ===== tb/rc_pulse_capture_decode_test.sv =====
`timescale 1ns / 1ps

module rc_pulse_capture_decode_test;

    import rcpc_pkg::*;

    localparam int NUM_CH = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            level;
        logic [TS_W-1:0] stamp;
    } pin_event_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [WIDTH_W-1:0] width;
        logic [DIR_W-1:0]   direction;
        logic [MAG_W-1:0]   magnitude;
        logic               present;
    } pulse_decode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rcpc_in_if  pulse_in ();
    rcpc_out_if result_out ();

    rc_pulse_capture_decode #(.NUM_CHANNELS(NUM_CH)) dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pulse_in   (pulse_in),
        .result_out (result_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // shadow of the block's registers and capture state
    logic [CFG_W-1:0] db_low     = RST_DEADBAND_LOW;
    logic [CFG_W-1:0] db_high    = RST_DEADBAND_HIGH;
    logic [CFG_W-1:0] rev_full   = RST_FULL_REVERSE;
    logic [CFG_W-1:0] fwd_full   = RST_FULL_FORWARD;
    logic [CFG_W-1:0] sig_thresh = RST_SIGNAL_THRESHOLD;
    logic [TS_W-1:0]  rise_stamp [NUM_CH];

    // generator bookkeeping for well-formed pulses
    logic             pulse_open  [NUM_CH];
    logic [TS_W-1:0]  pulse_began [NUM_CH];

    pin_event_t    pin_events[$];
    pulse_decode_t expected_decodes[$];

    int   send_idle_pct = 21;
    int   recv_idle_pct = 88;
    logic hold_off      = 1'b0;
    logic squeeze_go    = 1'b0;
    int   failures      = 0;

    function automatic logic [MAG_W-1:0] scale_drive(input longint offset, input longint span,
                                                     input longint gain, input longint base);
        longint v;
        if (span == 0)
            return MAG_FULL;
        v = offset * gain / span + base;
        if (v < 0)
            return '0;
        if (v > 255)
            return MAG_FULL;
        return v[MAG_W-1:0];
    endfunction

    function automatic bit decode_pin_event(input pin_event_t ev, output pulse_decode_t res);
        logic [TS_W-1:0]    elapsed;
        logic [WIDTH_W-1:0] w;
        res = '0;
        if (ev.channel >= NUM_CH)
            return 1'b0;
        if (ev.level)
        begin
            rise_stamp[ev.channel] = ev.stamp;
            return 1'b0;
        end
        elapsed = ev.stamp - rise_stamp[ev.channel];
        w = (elapsed > 32'd65535) ? 16'hFFFF : elapsed[WIDTH_W-1:0];
        res.channel = ev.channel;
        res.width   = w;
        res.present = (w > sig_thresh);
        // band test wins, even with an inverted band
        if (w >= db_low && w <= db_high)
        begin
            res.direction = DIR_STOP;
            res.magnitude = '0;
        end
        else if (w < db_low)
        begin
            res.direction = DIR_BELOW;
            res.magnitude = (w == 0) ? '0 :
                scale_drive(longint'(w) - longint'(rev_full),
                            longint'(db_low) - longint'(rev_full), -255, 255);
        end
        else
        begin
            res.direction = DIR_ABOVE;
            res.magnitude = scale_drive(longint'(w) - longint'(db_high),
                                        longint'(fwd_full) - longint'(db_high), 255, 0);
        end
        return 1'b1;
    endfunction

    function automatic logic [TS_W-1:0] pick_width();
        logic [TS_W-1:0] jitter;
        jitter = 32'($urandom_range(8)) - 32'd4;
        case ($urandom_range(10))
            0: return '0;
            1: return db_low + jitter;
            2: return db_high + jitter;
            3: return rev_full + jitter;
            4: return fwd_full + jitter;
            5: return sig_thresh + jitter;
            6, 7: return $urandom_range(3000);
            8: return 32'd65535 + jitter;
            9: return $urandom;
            default: return $urandom_range(65535);
        endcase
    endfunction

    task automatic add_edge(input int ch, input logic lvl, input logic [TS_W-1:0] stamp);
        pin_event_t ev;
        ev.channel = CH_W'(ch);
        ev.level   = lvl;
        ev.stamp   = stamp;
        pin_events.push_back(ev);
    endtask

    task automatic add_pulse(input int ch, input logic [TS_W-1:0] start,
                             input logic [TS_W-1:0] len);
        add_edge(ch, 1'b1, start);
        add_edge(ch, 1'b0, start + len);
    endtask

    task automatic queue_random_events(input int count);
        int         made;
        int         c;
        pin_event_t ev;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 12)
            begin
                // noise: any channel, either level, any time
                ev.channel = CH_W'($urandom_range(15));
                ev.level   = 1'($urandom_range(1));
                ev.stamp   = $urandom;
            end
            else
            begin
                c = $urandom_range(NUM_CH - 1);
                ev.channel = CH_W'(c);
                if (pulse_open[c])
                begin
                    ev.level = 1'b0;
                    ev.stamp = pulse_began[c] + pick_width();
                end
                else
                begin
                    ev.level       = 1'b1;
                    ev.stamp       = $urandom;
                    pulse_began[c] = ev.stamp;
                end
                pulse_open[c] = !pulse_open[c];
            end
            pin_events.push_back(ev);
            if (ev.channel < NUM_CH)
                made++;
        end
    endtask

    task automatic load_thresholds(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                   input logic [CFG_W-1:0] rev, input logic [CFG_W-1:0] fwd,
                                   input logic [CFG_W-1:0] thr);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [CFG_W-1:0]     val [6];
        idx = '{CFG_DEADBAND_LOW, CFG_DEADBAND_HIGH, CFG_FULL_REVERSE, CFG_FULL_FORWARD,
                CFG_SIGNAL_THRESHOLD, CFG_SPARE};
        // the spare index gets junk and must be ignored
        val = '{lo, hi, rev, fwd, thr, CFG_W'($urandom)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        db_low     = lo;
        db_high    = hi;
        rev_full   = rev;
        fwd_full   = fwd;
        sig_thresh = thr;
    endtask

    task automatic settle();
        while (pin_events.size() != 0 || pulse_in.valid || expected_decodes.size() != 0)
            @(posedge clk);
        // a rising edge may still be in flight with nothing expected
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: offers queued pin events, predicts each accepted request
    always @(posedge clk or negedge rst_n)
    begin : drive_pins
        pin_event_t    ev;
        pulse_decode_t res;
        if (!rst_n)
        begin
            pulse_in.valid <= 1'b0;
        end
        else
        begin
            if (pulse_in.valid && pulse_in.ready)
            begin
                ev.channel = pulse_in.channel;
                ev.level   = pulse_in.pin_level;
                ev.stamp   = pulse_in.timestamp_us;
                if (decode_pin_event(ev, res))
                    expected_decodes.push_back(res);
            end
            if (!pulse_in.valid || pulse_in.ready)
            begin
                if (pin_events.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    ev = pin_events.pop_front();
                    pulse_in.valid        <= 1'b1;
                    pulse_in.channel      <= ev.channel;
                    pulse_in.pin_level    <= ev.level;
                    pulse_in.timestamp_us <= ev.stamp;
                end
                else
                begin
                    pulse_in.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each decoded pulse against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_decodes
        pulse_decode_t got;
        pulse_decode_t want;
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                got.channel   = result_out.out_channel;
                got.width     = result_out.width_us;
                got.direction = result_out.direction;
                got.magnitude = result_out.magnitude;
                got.present   = result_out.signal_present;
                if (expected_decodes.size() == 0)
                begin
                    failures = failures + 1;
                    if (failures <= 10)
                        $display("unexpected decode: ch %0d width %0d dir %0d mag %0d sig %0d",
                                 got.channel, got.width, got.direction, got.magnitude,
                                 got.present);
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    if (got.channel !== want.channel || got.width !== want.width ||
                        got.direction !== want.direction || got.magnitude !== want.magnitude ||
                        got.present !== want.present)
                    begin
                        failures = failures + 1;
                        if (failures <= 10)
                        begin
                            $display("mismatch: want ch %0d width %0d dir %0d mag %0d sig %0d",
                                     want.channel, want.width, want.direction,
                                     want.magnitude, want.present);
                            $display("mismatch: got  ch %0d width %0d dir %0d mag %0d sig %0d",
                                     got.channel, got.width, got.direction,
                                     got.magnitude, got.present);
                        end
                    end
                end
            end
            result_out.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long output stall while the sender keeps pushing requests
    initial
    begin
        wait (squeeze_go);
        repeat (30) @(posedge clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("rc_pulse_capture_decode regression: fail");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        pulse_in.valid        = 1'b0;
        pulse_in.channel      = '0;
        pulse_in.pin_level    = 1'b0;
        pulse_in.timestamp_us = '0;
        result_out.ready      = 1'b0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            rise_stamp[i]  = '0;
            pulse_open[i]  = 1'b0;
            pulse_began[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed edges under the reset thresholds
        add_edge(1, 1'b0, 32'd0);                   // falling edge with no start seen
        add_pulse(0, 32'd1000, 32'd1500);           // center of the band
        add_pulse(0, 32'd10000, 32'd1480);          // band edges
        add_pulse(0, 32'd20000, 32'd1520);
        add_pulse(3, 32'd5, 32'd1479);              // just outside the band
        add_pulse(3, 32'd40000, 32'd1521);
        add_pulse(5, 32'd50000, 32'd900);           // past full reverse, clamps
        add_pulse(6, 32'd60000, 32'd700);           // signal threshold
        add_pulse(6, 32'd70000, 32'd701);
        add_pulse(10, 32'hFFFF_FF00, 32'd1280);     // timer wraps mid pulse
        add_pulse(2, 32'd0, 32'hFFFF_FFFF);         // long pulse saturates
        add_edge(15, 1'b0, 32'hFFFF_FFFF);          // channels past the last are ignored
        add_edge(11, 1'b1, 32'h1234_5678);
        add_edge(12, 1'b0, 32'h0000_0001);
        settle();

        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct <= 88;
                recv_idle_pct <= 21;
            end
            else if (phase == 4)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            case (phase)
                1: load_thresholds(16'd1000, 16'd2000, 16'd1200, 16'd1800, 16'd0);
                2: load_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                3: load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: load_thresholds(16'd2000, 16'd1000, 16'd500, 16'd3000, 16'd1500);
                5: load_thresholds(16'd1450, 16'd1550, 16'd1550, 16'd1450, 16'd1500);
                6: load_thresholds(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                   CFG_W'($urandom), CFG_W'($urandom));
                default: ;
            endcase
            queue_random_events(180);
            if (phase == 4)
                squeeze_go = 1'b1;
            settle();
        end

        if (failures == 0 && expected_decodes.size() == 0)
            $display("rc_pulse_capture_decode regression: pass");
        else
            $display("rc_pulse_capture_decode regression: fail");
        $finish;
    end

endmodule
